// File: src/gbfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared constants, result type and byte-wide CRC-16/XMODEM update for the
// binary frame parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

    localparam int BYTE_W          = 8;
    localparam int IDX_W           = 12;
    localparam int CRC_W           = 16;
    localparam int WORD_W          = 16;
    localparam int BLK_NUM_W       = 13;
    localparam int BLK_REV_W       = 3;
    localparam int LEN_OUT_W       = 12;
    localparam int M_TDATA_W       = 56;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int MIN_FRAME_BYTES = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h24;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h40;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

    localparam logic [IDX_W-1:0] IDX_SYNC_FIRST = 12'd0;
    localparam logic [IDX_W-1:0] IDX_CRC_LO     = 12'd2;
    localparam logic [IDX_W-1:0] IDX_ID_LO      = 12'd4;
    localparam logic [IDX_W-1:0] IDX_ID_HI      = 12'd5;
    localparam logic [IDX_W-1:0] IDX_LEN_LO     = 12'd6;
    localparam logic [IDX_W-1:0] IDX_BODY       = 12'd8;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] frame_length;
        logic [BLK_REV_W-1:0] block_revision;
        logic [BLK_NUM_W-1:0] block_number;
        logic                 crc_good;
        logic                 frame_end;
        logic                 in_frame;
        logic [IDX_W-1:0]     byte_index;
        logic [BYTE_W-1:0]    data_byte;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/gnss_binary_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser
// Finds binary frames in a received byte stream and checks their CRC.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while the output is not stalled and presents one
// result per byte: an input register, then the frame state machine with its
// byte-wide CRC-16/XMODEM update feeding the result register. Throughput is
// one byte per cycle while neither side stalls; both sides stall independently
// without losing or repeating bytes. m_tlast marks the last byte of a complete
// frame.
module gnss_binary_frame_parser (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gbfp_pkg::BYTE_W-1:0]    s_tdata,   // rx_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // data_byte[7:0], byte_index[19:8], in_frame[20], crc_good[21],
    // block_number[34:22], block_revision[37:35], frame_length[49:38], zero[55:50]
    output logic [gbfp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    logic                        byte_valid;
    logic                        byte_ready;
    logic [gbfp_pkg::BYTE_W-1:0] byte_data;
    gbfp_pkg::result_t           res;

    gbfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data)
    );

    gbfp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tlast = res.frame_end;
    assign m_tdata = {6'b0,
                      res.frame_length,
                      res.block_revision,
                      res.block_number,
                      res.crc_good,
                      res.in_frame,
                      res.byte_index,
                      res.data_byte};

endmodule
`default_nettype wire

// File: src/gbfp_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_in_stage
// Input register: captures one received byte per request and holds it until
// the parse stage takes it.
// ----------------------------------------------------------------------------
module gbfp_in_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [gbfp_pkg::BYTE_W-1:0] s_tdata,
    output logic                            byte_valid,
    input  wire logic                       byte_ready,
    output logic [gbfp_pkg::BYTE_W-1:0]     byte_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [gbfp_pkg::BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || byte_ready;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule
`default_nettype wire

// File: src/gbfp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_parse
// Frame state machine, running CRC and result register. One byte is parsed
// per cycle whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
module gbfp_parse (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        byte_valid,
    output logic                             byte_ready,
    input  wire logic [gbfp_pkg::BYTE_W-1:0] byte_data,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output gbfp_pkg::result_t                res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CRC,
        PH_HEAD,
        PH_BODY
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [gbfp_pkg::IDX_W-1:0]   count_reg, count_next;
    logic [gbfp_pkg::CRC_W-1:0]   exp_crc_reg, exp_crc_next;
    logic [gbfp_pkg::CRC_W-1:0]   run_crc_reg, run_crc_next;
    logic [gbfp_pkg::WORD_W-1:0]  frame_id_reg, frame_id_next;
    logic [gbfp_pkg::WORD_W-1:0]  len_reg, len_next;
    logic [gbfp_pkg::BYTE_W-1:0]  low_reg, low_next;
    logic                         out_valid_reg, out_valid_next;
    gbfp_pkg::result_t            out_reg, out_next;

    logic                         take;
    logic [gbfp_pkg::CRC_W-1:0]   crc_upd;
    logic [gbfp_pkg::WORD_W-1:0]  word_in;
    logic                         keep;
    logic                         fend;
    logic                         good;

    assign byte_ready = !out_valid_reg || res_ready;
    assign take       = byte_valid && byte_ready;
    assign crc_upd    = gbfp_pkg::crc_feed(run_crc_reg, byte_data);
    assign word_in    = {byte_data, low_reg};
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        exp_crc_next = exp_crc_reg;
        run_crc_next = run_crc_reg;
        frame_id_next = frame_id_reg;
        len_next     = len_reg;
        low_next     = low_reg;
        keep         = 1'b1;
        fend         = 1'b0;
        good         = 1'b0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (count_reg == gbfp_pkg::IDX_SYNC_FIRST) begin
                    if (byte_data == gbfp_pkg::SYNC_FIRST) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        keep = 1'b0;
                    end
                end else if (byte_data == gbfp_pkg::SYNC_SECOND) begin
                    phase_next = PH_CRC;
                    count_next = gbfp_pkg::IDX_CRC_LO;
                end else begin
                    keep       = 1'b0;
                    phase_next = PH_HUNT;
                    count_next = gbfp_pkg::IDX_SYNC_FIRST;
                end
            end
            PH_CRC: begin
                if (count_reg == gbfp_pkg::IDX_CRC_LO) begin
                    low_next   = byte_data;
                    count_next = count_reg + 1'b1;
                end else begin
                    exp_crc_next = word_in;
                    run_crc_next = '0;
                    phase_next   = PH_HEAD;
                    count_next   = gbfp_pkg::IDX_ID_LO;
                end
            end
            PH_HEAD: begin
                run_crc_next = crc_upd;
                if (count_reg == gbfp_pkg::IDX_ID_LO || count_reg == gbfp_pkg::IDX_LEN_LO) begin
                    low_next   = byte_data;
                    count_next = count_reg + 1'b1;
                end else if (count_reg == gbfp_pkg::IDX_ID_HI) begin
                    frame_id_next = word_in;
                    count_next    = gbfp_pkg::IDX_LEN_LO;
                end else begin
                    len_next = word_in;
                    if (word_in > gbfp_pkg::WORD_W'(gbfp_pkg::MIN_FRAME_BYTES)
                        && 17'(word_in) < 17'(gbfp_pkg::MAX_FRAME_BYTES)) begin
                        phase_next = PH_BODY;
                        count_next = gbfp_pkg::IDX_BODY;
                    end else begin
                        keep       = 1'b0;
                        phase_next = PH_HUNT;
                        count_next = gbfp_pkg::IDX_SYNC_FIRST;
                    end
                end
            end
            PH_BODY: begin
                run_crc_next = crc_upd;
                if (gbfp_pkg::WORD_W'(count_reg) + 16'd1 >= len_reg) begin
                    fend       = 1'b1;
                    good       = (crc_upd == exp_crc_reg);
                    phase_next = PH_HUNT;
                    count_next = gbfp_pkg::IDX_SYNC_FIRST;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase

        out_next.data_byte      = byte_data;
        out_next.byte_index     = count_reg;
        out_next.in_frame       = keep;
        out_next.frame_end      = fend;
        out_next.crc_good       = good;
        out_next.block_number   = frame_id_next[gbfp_pkg::BLK_NUM_W-1:0];
        out_next.block_revision = frame_id_next[gbfp_pkg::WORD_W-1:gbfp_pkg::BLK_NUM_W];
        out_next.frame_length   = len_next[gbfp_pkg::LEN_OUT_W-1:0];

        out_valid_next = out_valid_reg;
        if (byte_ready) begin
            out_valid_next = byte_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            exp_crc_reg   <= '0;
            run_crc_reg   <= '0;
            frame_id_reg  <= '0;
            len_reg       <= '0;
            low_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                exp_crc_reg  <= exp_crc_next;
                run_crc_reg  <= run_crc_next;
                frame_id_reg <= frame_id_next;
                len_reg      <= len_next;
                low_reg      <= low_next;
            end
        end
        if (take) begin
            out_reg <= out_next;
        end
    end

    a_good_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!out_reg.crc_good || out_reg.frame_end))
        else $error("crc_good without frame_end");

    a_end_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.frame_end |-> out_reg.in_frame)
        else $error("frame_end on a dropped byte");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> (count_reg >= gbfp_pkg::IDX_BODY
                                  && gbfp_pkg::WORD_W'(count_reg) < len_reg))
        else $error("body byte count out of range");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && fend |=> (phase_reg == PH_HUNT && count_reg == gbfp_pkg::IDX_SYNC_FIRST))
        else $error("frame end did not restart hunting");

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gnss_binary_frame_parser. Expected results are
// predicted by a local frame parser with its own CRC-16/XMODEM and compared,
// field by field and in order, with every result the block returns. Traffic
// covers the sync hunt, length limits, CRC checks, back pressure and random
// frames mixed with noise under varying idling.
// ----------------------------------------------------------------------------
module testbench;
    import gbfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        HUNT_SYNC,
        READ_CRC,
        READ_HEADER,
        READ_PAYLOAD
    } parse_phase_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int unsigned cycle_count    = 0;
    int unsigned hold_off_until = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          accepted_bytes = 0;
    int          mismatch_count = 0;

    result_t expected_results[$];

    parse_phase_t      parse_phase  = HUNT_SYNC;
    logic [IDX_W-1:0]  byte_count   = '0;
    logic [CRC_W-1:0]  stored_crc   = '0;
    logic [CRC_W-1:0]  running_crc  = '0;
    logic [WORD_W-1:0] frame_id     = '0;
    logic [WORD_W-1:0] length_field = '0;
    logic [BYTE_W-1:0] low_hold     = '0;

    gnss_binary_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL gnss_binary_frame_parser");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count < hold_off_until) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [CRC_W-1:0] crc16_xmodem_step(input logic [CRC_W-1:0] crc,
                                                          input logic [BYTE_W-1:0] d);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[CRC_W-1] ^ d[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic advance_parser(input logic [BYTE_W-1:0] rx, output result_t res);
        logic [IDX_W-1:0] idx;
        logic             keep;
        logic             fend;
        logic             good;
        idx  = byte_count;
        keep = 1'b1;
        fend = 1'b0;
        good = 1'b0;
        case (parse_phase)
            HUNT_SYNC: begin
                if (idx == IDX_SYNC_FIRST) begin
                    if (rx == SYNC_FIRST) begin
                        byte_count = idx + 1'b1;
                    end else begin
                        keep = 1'b0;
                    end
                end else if (rx == SYNC_SECOND) begin
                    parse_phase = READ_CRC;
                    byte_count  = IDX_CRC_LO;
                end else begin
                    keep        = 1'b0;
                    parse_phase = HUNT_SYNC;
                    byte_count  = IDX_SYNC_FIRST;
                end
            end
            READ_CRC: begin
                if (idx == IDX_CRC_LO) begin
                    low_hold   = rx;
                    byte_count = idx + 1'b1;
                end else begin
                    stored_crc  = {rx, low_hold};
                    running_crc = '0;
                    parse_phase = READ_HEADER;
                    byte_count  = IDX_ID_LO;
                end
            end
            READ_HEADER: begin
                running_crc = crc16_xmodem_step(running_crc, rx);
                if (idx == IDX_ID_LO || idx == IDX_LEN_LO) begin
                    low_hold   = rx;
                    byte_count = idx + 1'b1;
                end else if (idx == IDX_ID_HI) begin
                    frame_id   = {rx, low_hold};
                    byte_count = IDX_LEN_LO;
                end else begin
                    length_field = {rx, low_hold};
                    if (int'(length_field) > MIN_FRAME_BYTES &&
                        int'(length_field) < MAX_FRAME_BYTES) begin
                        parse_phase = READ_PAYLOAD;
                        byte_count  = IDX_BODY;
                    end else begin
                        keep        = 1'b0;
                        parse_phase = HUNT_SYNC;
                        byte_count  = IDX_SYNC_FIRST;
                    end
                end
            end
            default: begin
                running_crc = crc16_xmodem_step(running_crc, rx);
                if (int'(idx) + 1 >= int'(length_field)) begin
                    fend        = 1'b1;
                    good        = (running_crc == stored_crc);
                    parse_phase = HUNT_SYNC;
                    byte_count  = IDX_SYNC_FIRST;
                end else begin
                    byte_count = idx + 1'b1;
                end
            end
        endcase
        res.data_byte      = rx;
        res.byte_index     = idx;
        res.in_frame       = keep;
        res.frame_end      = fend;
        res.crc_good       = good;
        res.block_number   = frame_id[BLK_NUM_W-1:0];
        res.block_revision = frame_id[WORD_W-1:BLK_NUM_W];
        res.frame_length   = length_field[LEN_OUT_W-1:0];
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_byte      = m_tdata[7:0];
            got.byte_index     = m_tdata[19:8];
            got.in_frame       = m_tdata[20];
            got.crc_good       = m_tdata[21];
            got.block_number   = m_tdata[34:22];
            got.block_revision = m_tdata[37:35];
            got.frame_length   = m_tdata[49:38];
            got.frame_end      = m_tlast;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result at cycle %0d: tdata=%h tlast=%b",
                             cycle_count, m_tdata, m_tlast);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.data_byte != want.data_byte || got.byte_index != want.byte_index ||
                    got.in_frame != want.in_frame || got.frame_end != want.frame_end ||
                    got.crc_good != want.crc_good || got.block_number != want.block_number ||
                    got.block_revision != want.block_revision ||
                    got.frame_length != want.frame_length || m_tdata[55:50] != '0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch at cycle %0d (pad %h)", cycle_count,
                                 m_tdata[55:50]);
                        $display("  expected byte=%h idx=%0d in=%b end=%b ",
                                 want.data_byte, want.byte_index, want.in_frame,
                                 want.frame_end,
                                 "good=%b blk=%0d rev=%0d len=%0d",
                                 want.crc_good, want.block_number,
                                 want.block_revision, want.frame_length);
                        $display("  actual   byte=%h idx=%0d in=%b end=%b ",
                                 got.data_byte, got.byte_index, got.in_frame,
                                 got.frame_end,
                                 "good=%b blk=%0d rev=%0d len=%0d",
                                 got.crc_good, got.block_number,
                                 got.block_revision, got.frame_length);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        result_t res;
        int      gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        advance_parser(rx, res);
        expected_results.push_back(res);
        accepted_bytes++;
    endtask

    task automatic send_frame(input logic [WORD_W-1:0] id, input logic [WORD_W-1:0] total_len,
                              input bit corrupt_crc);
        logic [BYTE_W-1:0] body[$];
        logic [CRC_W-1:0]  crc;
        int                n;
        body = {id[7:0], id[15:8], total_len[7:0], total_len[15:8]};
        n    = (int'(total_len) > MIN_FRAME_BYTES && int'(total_len) < MAX_FRAME_BYTES) ?
               int'(total_len) : MIN_FRAME_BYTES;
        while (body.size() < n - 4) begin
            body.push_back(BYTE_W'($urandom_range(255)));
        end
        crc = '0;
        foreach (body[i]) begin
            crc = crc16_xmodem_step(crc, body[i]);
        end
        if (corrupt_crc) begin
            crc = crc ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        end
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 85) begin
            return WORD_W'($urandom_range(40, MIN_FRAME_BYTES + 1));
        end else if (r < 97) begin
            return WORD_W'($urandom_range(300, 41));
        end
        return WORD_W'($urandom_range(600, 301));
    endfunction

    function automatic logic [WORD_W-1:0] pick_bad_length();
        if ($urandom_range(1) == 0) begin
            return WORD_W'($urandom_range(MIN_FRAME_BYTES));
        end
        return WORD_W'($urandom_range(16'hFFFF, MAX_FRAME_BYTES));
    endfunction

    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_SECOND);
    endtask

    task automatic test_length_limits();
        send_frame(16'hFFFF, WORD_W'(MIN_FRAME_BYTES), 1'b0);
        send_frame(16'h0000, WORD_W'(MAX_FRAME_BYTES), 1'b0);
        send_frame(16'hA5C3, WORD_W'(MIN_FRAME_BYTES + 1), 1'b0);
    endtask

    task automatic test_crc_check();
        send_frame(16'h1234, 16'd12, 1'b1);
        send_frame(16'hE000, 16'hFFFF, 1'b0);
    endtask

    task automatic test_back_pressure();
        hold_off_until = cycle_count + 300;
        send_frame(WORD_W'($urandom), 16'd60, 1'b0);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
        int stop_at;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = accepted_bytes + n_bytes;
        while (accepted_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                send_frame(WORD_W'($urandom), pick_length(), $urandom_range(7) == 0);
            end else if (pick < 82) begin
                repeat ($urandom_range(6, 1)) begin
                    send_byte(($urandom_range(3) == 0) ? SYNC_FIRST :
                              BYTE_W'($urandom_range(255)));
                end
            end else if (pick < 90) begin
                send_byte(SYNC_FIRST);
                send_byte(($urandom_range(1) == 0) ? SYNC_FIRST :
                          BYTE_W'($urandom_range(255)) ^ SYNC_SECOND | 8'h01);
            end else begin
                send_frame(WORD_W'($urandom), pick_bad_length(), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 20;
        rx_idle_pct = 81;
        test_sync_hunt();
        test_length_limits();
        test_crc_check();

        test_random_traffic(20, 81, 470);
        test_random_traffic(81, 20, 470);
        test_random_traffic(0, 0, 460);

        test_back_pressure();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS gnss_binary_frame_parser");
        end else begin
            $display("FAIL gnss_binary_frame_parser");
        end
        $finish;
    end

endmodule

// File: files.f
src/gbfp_pkg.sv
src/gbfp_in_stage.sv
src/gbfp_parse.sv
src/gnss_binary_frame_parser.sv
sim/testbench.sv
